### rtl/core/psg_tone_generator_unit_macros.svh
// assertion macros shared by the tone generator rtl
`ifndef PSG_TONE_GENERATOR_UNIT_MACROS_SVH
`define PSG_TONE_GENERATOR_UNIT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define PSG_ASSERT_SAME(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define PSG_ASSERT_NEXT(lbl, trig, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

### rtl/core/psg_pkg.sv
// shared types, constants and the level table of the tone generator
package psg_pkg;

   localparam int NUM_CHANNELS      = 3;
   localparam int CHAN_SEL_W        = 2;
   localparam int PERIOD_W          = 10;
   localparam int ATTEN_W           = 4;
   localparam int BYTE_W            = 8;
   localparam int CYCLES_W          = 10;
   localparam int SAMPLE_W          = 16;
   localparam int LEVEL_W           = 14;
   localparam int CONTRIB_W         = LEVEL_W + 1;

   localparam int PRESCALE_DIVIDE   = 16;
   localparam int FRAC_W            = $clog2(PRESCALE_DIVIDE);
   localparam int TOTAL_W           = $clog2((2 ** CYCLES_W) + PRESCALE_DIVIDE);
   localparam int MAX_STEPS         = ((2 ** CYCLES_W) - 1 + PRESCALE_DIVIDE - 1)
                                      / PRESCALE_DIVIDE;
   localparam int STEPS_W           = $clog2(MAX_STEPS + 1);

   localparam int COUNT_W           = 17;
   localparam int LIMIT_W           = 16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam int CSR_DATA_W        = LIMIT_W;
   localparam int CSR_INDEX_W       = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE      = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECIM_LIMIT = 1'd1;
   localparam logic                   ENABLE_RESET    = 1'b1;
   localparam logic [LIMIT_W-1:0]     LIMIT_RESET     = 16'd4;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // per channel register write strobes decoded from the port byte
   typedef struct packed {
      logic       vol_we;
      logic       lo_we;
      logic       hi_we;
      logic [5:0] data;
   } psg_chan_write_type;

   // prescaler / decimator result for the tick in flight
   typedef struct packed {
      logic               emit;
      logic [STEPS_W-1:0] steps;
   } psg_tick_status_type;

   // 8000 * 0.8^a rounded down, silent at full attenuation
   function automatic logic [LEVEL_W-1:0] psg_level(input logic [ATTEN_W-1:0] atten);
      logic [LEVEL_W-1:0] lvl;
      case (atten)
         4'd0:    lvl = 14'd8000;
         4'd1:    lvl = 14'd6400;
         4'd2:    lvl = 14'd5120;
         4'd3:    lvl = 14'd4096;
         4'd4:    lvl = 14'd3276;
         4'd5:    lvl = 14'd2621;
         4'd6:    lvl = 14'd2097;
         4'd7:    lvl = 14'd1677;
         4'd8:    lvl = 14'd1342;
         4'd9:    lvl = 14'd1073;
         4'd10:   lvl = 14'd858;
         4'd11:   lvl = 14'd687;
         4'd12:   lvl = 14'd549;
         4'd13:   lvl = 14'd439;
         4'd14:   lvl = 14'd351;
         default: lvl = 14'd0;
      endcase
      return lvl;
   endfunction

endpackage

### rtl/core/psg_chan_if.sv
// valid/ready channel interfaces for requests and samples
interface psg_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic [psg_pkg::BYTE_W-1:0]     data_byte;
   logic [psg_pkg::CYCLES_W-1:0]   clock_cycles;

   modport source (output valid, output cmd, output data_byte, output clock_cycles,
                   input ready);
   modport sink   (input valid, input cmd, input data_byte, input clock_cycles,
                   output ready);
endinterface

interface psg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [psg_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

### rtl/core/psg_tone_channel.sv
// one square wave tone channel: period, attenuation, counter and polarity
module psg_tone_channel (
   input  logic                                  clock,
   input  logic                                  reset,
   input  psg_pkg::psg_chan_write_type           wr,
   input  logic                                  tick_go,
   input  logic [psg_pkg::STEPS_W-1:0]           steps,
   output logic signed [psg_pkg::CONTRIB_W-1:0]  contrib
);

   logic [psg_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [psg_pkg::ATTEN_W-1:0]  atten_ff, atten_in;
   logic [psg_pkg::PERIOD_W-1:0] counter_ff, counter_in;
   logic                         neg_ff, neg_in;

   logic                         active;
   logic                         reload;
   logic                         neg_next;
   logic signed [psg_pkg::CONTRIB_W-1:0] level_s;

   // stored counter never goes below one once running, so no sign is kept
   assign active   = (period_ff != '0);
   assign reload   = ({1'b0, counter_ff} <= (psg_pkg::PERIOD_W + 1)'(steps));
   assign neg_next = reload ? ~neg_ff : neg_ff;
   assign level_s  = $signed({1'b0, psg_pkg::psg_level(atten_ff)});
   assign contrib  = !active ? '0 : (neg_next ? -level_s : level_s);

   always_comb begin
      period_in  = period_ff;
      atten_in   = atten_ff;
      counter_in = counter_ff;
      neg_in     = neg_ff;
      if (wr.vol_we) begin
         atten_in = wr.data[psg_pkg::ATTEN_W-1:0];
      end
      if (wr.lo_we) begin
         period_in[3:0] = wr.data[3:0];
      end
      if (wr.hi_we) begin
         period_in[psg_pkg::PERIOD_W-1:4] = wr.data;
      end
      if (tick_go && active) begin
         counter_in = reload ? period_ff : counter_ff - psg_pkg::PERIOD_W'(steps);
         neg_in     = neg_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= '0;
         atten_ff   <= '0;
         counter_ff <= '0;
         neg_ff     <= 1'b0;
      end else begin
         period_ff  <= period_in;
         atten_ff   <= atten_in;
         counter_ff <= counter_in;
         neg_ff     <= neg_in;
      end
   end

endmodule

### rtl/core/psg_timebase.sv
// divide-by-16 prescaler and sample decimator
module psg_timebase (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                tick_go,
   input  logic [psg_pkg::CYCLES_W-1:0]        clock_cycles,
   input  logic [psg_pkg::LIMIT_W-1:0]         limit,
   output psg_pkg::psg_tick_status_type        status
);

   logic [psg_pkg::FRAC_W-1:0]   frac_ff, frac_in;
   logic [psg_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic [psg_pkg::TOTAL_W-1:0]  total;
   logic [psg_pkg::COUNT_W:0]    count_sum;
   logic [psg_pkg::COUNT_W-1:0]  count_sat;
   logic [psg_pkg::LIMIT_W-1:0]  limit_eff;

   assign total        = psg_pkg::TOTAL_W'(frac_ff) + psg_pkg::TOTAL_W'(clock_cycles);
   assign status.steps = psg_pkg::STEPS_W'(total / psg_pkg::PRESCALE_DIVIDE);

   assign count_sum = (psg_pkg::COUNT_W + 1)'(count_ff) + (psg_pkg::COUNT_W + 1)'(status.steps);
   assign count_sat = count_sum[psg_pkg::COUNT_W] ? psg_pkg::COUNT_MAX
                                                  : count_sum[psg_pkg::COUNT_W-1:0];
   // a zero limit behaves as one
   assign limit_eff   = (limit == '0) ? psg_pkg::LIMIT_W'(1) : limit;
   assign status.emit = (count_sat >= psg_pkg::COUNT_W'(limit_eff));

   always_comb begin
      frac_in  = frac_ff;
      count_in = count_ff;
      if (tick_go) begin
         frac_in  = psg_pkg::FRAC_W'(total % psg_pkg::PRESCALE_DIVIDE);
         count_in = status.emit ? count_sat - psg_pkg::COUNT_W'(limit_eff) : count_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff  <= '0;
         count_ff <= '0;
      end else begin
         frac_ff  <= frac_in;
         count_ff <= count_in;
      end
   end

endmodule

### rtl/core/psg_tone_generator_unit.sv
// top level of the three channel tone generator
// Three square wave tone channels behind a byte-wide sound port. A request
// transaction is either a port byte (cmd 0: latch byte with bit 7 set, or a
// data byte for the latched register) or a tick (cmd 1) carrying elapsed
// input clock cycles; ticks feed a divide-by-16 prescaler whose whole steps
// count down every channel with a non-zero period and feed a decimator that
// emits one signed sample, the sum of the three channel levels, each time
// its step count reaches decimation_limit. Writes and ticks below the limit
// give no response transaction. A request is taken every cycle unless the
// input stage stalls: it is held in the input register, where the channel
// and decimator logic resolves it, and a sample lands in the output
// register as the input stage retires, which raises rsp valid. Only
// a sample that cannot leave while the previous one is still unread stalls
// the request side. Configuration (csr_index 0 enable,
// 1 decimation_limit) should only be written while no transaction is in
// flight; with enable low, ticks are dropped but writes still land.
module psg_tone_generator_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   psg_req_if.sink                              req_chan,
   psg_rsp_if.source                            rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [psg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [psg_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   `include "psg_tone_generator_unit_macros.svh"

   // configuration registers
   logic                          enable_ff, enable_in;
   logic [psg_pkg::LIMIT_W-1:0]   limit_ff, limit_in;

   // input register stage
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_cmd_ff, s1_cmd_in;
   logic [psg_pkg::BYTE_W-1:0]    s1_byte_ff, s1_byte_in;
   logic [psg_pkg::CYCLES_W-1:0]  s1_cycles_ff, s1_cycles_in;

   // port latch
   logic [psg_pkg::CHAN_SEL_W-1:0] latch_ch_ff, latch_ch_in;
   logic                           latch_vol_ff, latch_vol_in;

   // output register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [psg_pkg::SAMPLE_W-1:0]   sample_ff, sample_in;

   logic                                  req_accept;
   logic                                  s1_emit;
   logic                                  s1_advance;
   logic                                  tick_go;
   logic                                  write_go;
   logic [psg_pkg::CHAN_SEL_W-1:0]        wr_ch;
   logic                                  wr_vol;
   logic                                  wr_is_latch;
   psg_pkg::psg_tick_status_type          tb_status;
   psg_pkg::psg_chan_write_type           chan_wr [psg_pkg::NUM_CHANNELS];
   logic signed [psg_pkg::CONTRIB_W-1:0]  contrib [psg_pkg::NUM_CHANNELS];
   logic signed [psg_pkg::SAMPLE_W-1:0]   sum;

   // ---------------------------------------------------------------------
   // handshake: the input stage moves on unless its sample would overwrite
   // an unread one
   // ---------------------------------------------------------------------
   assign s1_emit    = s1_valid_ff && (s1_cmd_ff == psg_pkg::CMD_TICK) && enable_ff
                       && tb_status.emit;
   assign s1_advance = !s1_emit || !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_accept = req_chan.valid && req_chan.ready;

   // state only changes once the transaction in the input stage retires
   assign tick_go  = s1_valid_ff && s1_advance && (s1_cmd_ff == psg_pkg::CMD_TICK)
                     && enable_ff;
   assign write_go = s1_valid_ff && s1_advance && (s1_cmd_ff == psg_pkg::CMD_WRITE);

   // ---------------------------------------------------------------------
   // port byte decode: a latch byte names channel and register itself,
   // a data byte goes to whatever was latched last
   // ---------------------------------------------------------------------
   assign wr_is_latch = s1_byte_ff[7];
   assign wr_ch       = wr_is_latch ? s1_byte_ff[6:5] : latch_ch_ff;
   assign wr_vol      = wr_is_latch ? s1_byte_ff[4]   : latch_vol_ff;

   always_comb begin
      latch_ch_in  = latch_ch_ff;
      latch_vol_in = latch_vol_ff;
      if (write_go && wr_is_latch) begin
         latch_ch_in  = s1_byte_ff[6:5];
         latch_vol_in = s1_byte_ff[4];
      end
   end

   // the noise channel select matches no tone channel, so it writes nothing
   for (genvar i = 0; i < psg_pkg::NUM_CHANNELS; i++) begin : g_chan
      logic hit;
      assign hit = write_go && (wr_ch == psg_pkg::CHAN_SEL_W'(i));
      assign chan_wr[i].vol_we = hit && wr_vol;
      assign chan_wr[i].lo_we  = hit && !wr_vol && wr_is_latch;
      assign chan_wr[i].hi_we  = hit && !wr_vol && !wr_is_latch;
      assign chan_wr[i].data   = s1_byte_ff[5:0];

      psg_tone_channel u_chan (
         .clock   (clock),
         .reset   (reset),
         .wr      (chan_wr[i]),
         .tick_go (tick_go),
         .steps   (tb_status.steps),
         .contrib (contrib[i])
      );
   end

   psg_timebase u_timebase (
      .clock        (clock),
      .reset        (reset),
      .tick_go      (tick_go),
      .clock_cycles (s1_cycles_ff),
      .limit        (limit_ff),
      .status       (tb_status)
   );

   // channel levels already reflect this tick's polarity flips
   always_comb begin
      sum = '0;
      for (int i = 0; i < psg_pkg::NUM_CHANNELS; i++) begin
         sum = sum + psg_pkg::SAMPLE_W'(contrib[i]);
      end
   end

   // ---------------------------------------------------------------------
   // register next values
   // ---------------------------------------------------------------------
   always_comb begin
      enable_in = enable_ff;
      limit_in  = limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            psg_pkg::CSR_ENABLE:      enable_in = csr_write_data[0];
            psg_pkg::CSR_DECIM_LIMIT: limit_in  = csr_write_data;
            default:                  ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_cmd_in    = s1_cmd_ff;
      s1_byte_in   = s1_byte_ff;
      s1_cycles_in = s1_cycles_ff;
      if (req_accept) begin
         s1_valid_in  = 1'b1;
         s1_cmd_in    = req_chan.cmd;
         s1_byte_in   = req_chan.data_byte;
         s1_cycles_in = req_chan.clock_cycles;
      end else if (s1_advance) begin
         s1_valid_in  = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      sample_in    = sample_ff;
      if (s1_emit && s1_advance) begin
         rsp_valid_in = 1'b1;
         sample_in    = sum;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= psg_pkg::ENABLE_RESET;
         limit_ff     <= psg_pkg::LIMIT_RESET;
         s1_valid_ff  <= 1'b0;
         latch_ch_ff  <= '0;
         latch_vol_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         limit_ff     <= limit_in;
         s1_valid_ff  <= s1_valid_in;
         latch_ch_ff  <= latch_ch_in;
         latch_vol_ff <= latch_vol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      s1_cmd_ff    <= s1_cmd_in;
      s1_byte_ff   <= s1_byte_in;
      s1_cycles_ff <= s1_cycles_in;
      sample_ff    <= sample_in;
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.sample = sample_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `PSG_ASSERT_NEXT(a_write_no_sample, write_go && !rsp_valid_ff, !rsp_valid_ff, "port write produced a sample")
   `PSG_ASSERT_SAME(a_emit_needs_tick, s1_emit && s1_advance, tick_go, "sample loaded without an enabled tick")
   `PSG_ASSERT_SAME(a_stall_means_full, !req_chan.ready, s1_valid_ff && rsp_valid_ff, "request stalled with room to spare")

endmodule
